### design/ppct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_pkg
// Shared types, constants and codes of the pulse peak CFD timer.
// ----------------------------------------------------------------------------
package ppct_pkg;
	localparam int RECORD_LEN_DEF  = 4096;
	localparam int RAW_W_DEF       = 16;
	localparam int FRAC_BITS_DEF   = 8;

	localparam int THR_W  = 15;
	localparam int CF_W   = 8;
	localparam int AMP_W  = 15;
	localparam int IDX_W  = 12;
	localparam int TIME_W = 20;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CF_FRACTION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLAMP_LIMIT = 2'd2;

	localparam logic [THR_W-1:0] THRESHOLD_RST = 15'd100;
	localparam logic [CF_W-1:0]  CF_RST        = 8'd128;
	localparam logic [THR_W-1:0] CLAMP_RST     = 15'd9000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_RD_NEXT,
		ST_DIV,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic take;      // accept sample
		logic start;     // begin a search (latch run)
		logic rd_cur;    // read store at search pointer
		logic step;      // decrement search pointer
		logic rd_next;   // read store at pointer + 1
		logic div_start;
		logic no_hit;    // finish without crossing
		logic emit;      // load output register
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic need_result;  // accepted sample closes a run
		logic ptr_zero;
		logic below;        // current value below level
		logic div_done;
		logic out_busy;
	} stat_t;
endpackage

### design/ppct_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_if
// Valid/ready channels: input samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface ppct_in_if #(parameter int RAW_W = 16);
	logic                    valid;
	logic                    ready;
	logic signed [RAW_W-1:0] raw_sample;
	logic                    last_in_record;
	modport source (output valid, raw_sample, last_in_record, input ready);
	modport sink (input valid, raw_sample, last_in_record, output ready);
endinterface

interface ppct_out_if;
	logic        valid;
	logic        ready;
	logic [14:0] peak_amplitude;
	logic [11:0] peak_index;
	logic [19:0] cf_time;
	logic        cf_found;
	modport source (output valid, peak_amplitude, peak_index, cf_time, cf_found,
		input ready);
	modport sink (input valid, peak_amplitude, peak_index, cf_time, cf_found,
		output ready);
endinterface

interface ppct_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [14:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### design/ppct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_ctrl
// Sequencer: sample intake, backward search, interpolation divide, output.
// ----------------------------------------------------------------------------
module ppct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  ppct_pkg::stat_t st,
	output ppct_pkg::ctrl_t cmd
);
	import ppct_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && st.need_result) state_nxt = ST_RD;
			end
			ST_RD: state_nxt = ST_CMP;
			ST_CMP: begin
				if (st.below) state_nxt = ST_RD_NEXT;
				else if (st.ptr_zero) state_nxt = ST_OUT;
				else state_nxt = ST_RD;
			end
			ST_RD_NEXT: state_nxt = ST_DIV;
			ST_DIV: begin
				if (st.div_done) state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (!st.out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// a pending result holds the controller in ST_OUT, which blocks the intake as well
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.take  = in_valid;
				cmd.start = in_valid && st.need_result;
			end
			ST_RD: cmd.rd_cur = 1'b1;
			ST_CMP: begin
				cmd.step    = !st.below && !st.ptr_zero;
				cmd.rd_next = st.below;
				cmd.no_hit  = !st.below && st.ptr_zero;
			end
			ST_RD_NEXT: cmd.div_start = 1'b1;
			ST_OUT: cmd.emit = !st.out_busy;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |=> state_q == ST_DIV || state_q == ST_OUT)
		else $error("divide left to wrong state");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> !st.ptr_zero)
		else $error("search stepped past index zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("sample taken during search");
endmodule

### design/ppct_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_dp
// Datapath: clamp, sample store, run tracking, search pointer, divider,
// output register.
// ----------------------------------------------------------------------------
module ppct_dp #(
	parameter int RECORD_LEN  = ppct_pkg::RECORD_LEN_DEF,
	parameter int RAW_W       = ppct_pkg::RAW_W_DEF,
	parameter int FRAC_BITS   = ppct_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic signed [RAW_W-1:0]        raw_sample,
	input  logic                           last_in_record,
	input  logic [ppct_pkg::THR_W-1:0]     threshold,
	input  logic [ppct_pkg::CF_W-1:0]      cf_fraction,
	input  logic [ppct_pkg::THR_W-1:0]     clamp_limit,
	input  ppct_pkg::ctrl_t                cmd,
	output ppct_pkg::stat_t                st,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ppct_pkg::AMP_W-1:0]     peak_amplitude,
	output logic [ppct_pkg::IDX_W-1:0]     peak_index,
	output logic [ppct_pkg::TIME_W-1:0]    cf_time,
	output logic                           cf_found
);
	import ppct_pkg::*;

	localparam int AW  = $clog2(RECORD_LEN);
	localparam int VW  = RAW_W + 1;                  // signed stored value
	localparam int LW  = RAW_W + CF_W + 1;           // level, signed
	localparam int NW  = LW + FRAC_BITS;             // dividend width
	localparam int DW  = VW + 1 + 8;                 // divisor width
	localparam int QCW = $clog2(NW + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(RECORD_LEN - 1);
	localparam logic [FRAC_BITS-1:0] FRAC_TOP = '1;

	// ---- sample transform ----
	logic signed [VW-1:0] neg_v, val;
	assign neg_v = -VW'(raw_sample);
	assign val = (neg_v > $signed({2'b0, clamp_limit})) ? '0 : neg_v;
	logic above;
	assign above = val > $signed({2'b0, threshold});

	// ---- run tracking ----
	logic [AW-1:0]     cnt_q;
	logic              in_pulse_q;
	logic [VW-2:0]     run_max_q;
	logic [AW-1:0]     run_idx_q;
	logic [VW-2:0]     max_nxt;
	logic [AW-1:0]     idx_nxt;
	logic              ends;

	always_comb begin
		max_nxt = in_pulse_q ? run_max_q : '0;
		idx_nxt = in_pulse_q ? run_idx_q : cnt_q;
		if (above && val[VW-2:0] > max_nxt) begin
			max_nxt = val[VW-2:0];
			idx_nxt = cnt_q;
		end
	end
	assign ends = above ? last_in_record : in_pulse_q;
	assign st.need_result = ends;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			in_pulse_q <= 1'b0;
			run_max_q  <= '0;
			run_idx_q  <= '0;
		end else if (cmd.take) begin
			cnt_q      <= last_in_record ? '0 : ((cnt_q == LAST_ADDR) ? '0 : cnt_q + 1'b1);
			in_pulse_q <= above && !last_in_record;
			if (above) begin
				run_max_q <= max_nxt;
				run_idx_q <= idx_nxt;
			end
		end
	end

	// ---- sample store ----
	logic signed [VW-1:0] mem [RECORD_LEN];
	logic signed [VW-1:0] rd_q;
	logic [AW-1:0]        ptr_q;
	logic [AW-1:0]        ptr_p1;
	assign ptr_p1 = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.take) mem[cnt_q] <= val;
		if (cmd.rd_cur) rd_q <= mem[ptr_q];
		else if (cmd.rd_next) rd_q <= mem[ptr_p1];
	end

	// ---- search ----
	logic [VW-2:0]        pk_q;
	logic [AW-1:0]        pk_idx_q;
	logic signed [LW-1:0] level_q;
	logic signed [VW-1:0] y2_q;
	logic signed [LW-1:0] y2s;
	logic                 nohit_q;
	assign y2s = LW'(rd_q) <<< 8;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pk_q     <= max_nxt;
			pk_idx_q <= idx_nxt;
			ptr_q    <= idx_nxt;
		end
		if (cmd.start) nohit_q <= 1'b0;
		else if (cmd.no_hit) nohit_q <= 1'b1;
		if (cmd.rd_cur) level_q <= $signed({1'b0, cf_fraction}) * $signed({1'b0, pk_q});
		if (cmd.step) ptr_q <= ptr_q - 1'b1;
		if (cmd.rd_next) y2_q <= rd_q;
	end
	assign st.ptr_zero = ptr_q == '0;
	assign st.below = !st.ptr_zero && (y2s < level_q);

	// ---- restoring divider: (num << FRAC_BITS) / den ----
	logic [NW-1:0]  rem_q, quo_q;
	logic [DW-1:0]  den_q;
	logic [QCW-1:0] dcnt_q;
	logic           dbusy_q, dok_q;
	logic signed [DW-1:0] den_w;
	logic signed [LW-1:0] num_w;
	logic [NW:0]    trial;
	assign den_w = (DW'(rd_q) - DW'(y2_q)) <<< 8;
	assign num_w = level_q - (LW'(y2_q) <<< 8);
	assign trial = {rem_q, quo_q[NW-1]} - (NW+1)'(den_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dbusy_q <= 1'b0;
		end else if (cmd.div_start) begin
			dbusy_q <= (den_w > 0) && (num_w > 0);
		end else if (dbusy_q && dcnt_q == '0) begin
			dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dok_q  <= (den_w > 0) && (num_w > 0);
			den_q  <= den_w;
			rem_q  <= '0;
			quo_q  <= NW'(num_w) << FRAC_BITS;
			dcnt_q <= QCW'(NW - 1);
		end else if (dbusy_q) begin
			dcnt_q <= dcnt_q - 1'b1;
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[NW-2:0], quo_q[NW-1]};
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end
	assign st.div_done = !dbusy_q;

	logic [FRAC_BITS-1:0] frac;
	always_comb begin
		if (!dok_q) frac = '0;
		else if (quo_q > NW'(FRAC_TOP)) frac = FRAC_TOP;
		else frac = quo_q[FRAC_BITS-1:0];
	end

	// ---- output register ----
	logic [AW+FRAC_BITS-1:0] time_full;
	assign time_full = {ptr_q, frac};
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			peak_amplitude <= AMP_W'(pk_q);
			peak_index     <= IDX_W'(pk_idx_q);
			cf_found       <= !nohit_q;
			cf_time        <= nohit_q ? '0 : TIME_W'(time_full);
		end
	end
	assign out_valid   = out_valid_q;
	assign st.out_busy = out_valid_q && !out_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> cmd.take)
		else $error("search started without a sample");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && last_in_record |=> cnt_q == '0 && !in_pulse_q)
		else $error("record end did not restart index");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !dbusy_q)
		else $error("result emitted while dividing");
endmodule

### design/pulse_peak_cfd_timer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_peak_cfd_timer_top
// Threshold peak finder with constant-fraction timing.
// ----------------------------------------------------------------------------
// A sample that does not close a run is taken in IDLE. One that closes a run (peak p,
// crossing t) holds the input while each index from p down to t is read and compared,
// the neighbor is read, the divide runs (NW = RAW_W+CF_W+1+FRAC_BITS = 33 bits) and the
// output loads; no crossing searches down to index zero; a waiting result adds stall.
// Reset (arst_n low) restores register defaults and clears run state;
// the sample store holds no reset value.
module pulse_peak_cfd_timer_top #(
	parameter int RECORD_LEN  = ppct_pkg::RECORD_LEN_DEF,
	parameter int RAW_W       = ppct_pkg::RAW_W_DEF,
	parameter int FRAC_BITS   = ppct_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ppct_in_if.sink   in_ch,
	ppct_out_if.source out_ch,
	ppct_cfg_if.sink  cfg
);
	import ppct_pkg::*;

	logic [THR_W-1:0] threshold_q, clamp_q;
	logic [CF_W-1:0]  cf_q;
	ctrl_t cmd;
	stat_t st;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			cf_q        <= CF_RST;
			clamp_q     <= CLAMP_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_THRESHOLD:   threshold_q <= cfg.data;
				REG_CF_FRACTION: cf_q <= cfg.data[CF_W-1:0];
				REG_CLAMP_LIMIT: clamp_q <= cfg.data;
				default: ;
			endcase
		end
	end

	ppct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.st(st), .cmd(cmd)
	);

	ppct_dp #(.RECORD_LEN(RECORD_LEN), .RAW_W(RAW_W),
		.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.raw_sample(in_ch.raw_sample), .last_in_record(in_ch.last_in_record),
		.threshold(threshold_q), .cf_fraction(cf_q), .clamp_limit(clamp_q),
		.cmd(cmd), .st(st),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.peak_amplitude(out_ch.peak_amplitude), .peak_index(out_ch.peak_index),
		.cf_time(out_ch.cf_time), .cf_found(out_ch.cf_found)
	);
endmodule

### sim/tb_pulse_peak_cfd_timer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pulse_peak_cfd_timer_top
// Self-checking bench for the pulse peak CFD timer. A directed table covers
// the extremes and corner cases of peak search and crossing interpolation.
// Random records of shaped pulses and noise follow under several register
// settings and handshake idle patterns. Each result is checked against an
// in-bench peak/CFD predictor.
// ----------------------------------------------------------------------------
module tb_pulse_peak_cfd_timer_top;
	import ppct_pkg::*;

	localparam int NREC = 4096;

	typedef struct packed {
		logic [AMP_W-1:0]  amp;
		logic [IDX_W-1:0]  idx;
		logic [TIME_W-1:0] tm;
		logic              found;
	} pulse_res_t;

	typedef struct {
		int         raw;
		bit         last;
		bit         typed;
		pulse_res_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	ppct_in_if #(.RAW_W(16)) in_ch();
	ppct_out_if  out_ch();
	ppct_cfg_if  cfg();

	pulse_peak_cfd_timer_top dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg(cfg)
	);

	// predictor state
	int  thr_q, cf_q, clamp_q;
	int  wave_mem [NREC];
	int  wr_ptr;
	bit  pulse_on;
	int  pk_amp, pk_idx;

	pulse_res_t pulse_q[$];
	int  errors;
	int  idle_pct, stall_pct, hold_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic pulse_res_t cfd_search();
		pulse_res_t r;
		longint level, y1, y2, num, den, frac;
		int t;
		r = '0;
		level = longint'(cf_q) * pk_amp;
		for (t = pk_idx % NREC; t > 0; t--) begin
			y2 = wave_mem[t];
			if (y2 * 256 < level) begin
				y1 = wave_mem[(t + 1) % NREC];
				den = (y1 - y2) * 256;
				num = level - y2 * 256;
				frac = 0;
				if (den > 0 && num > 0) begin
					frac = (num <<< 8) / den;
					if (frac > 255) frac = 255;
				end
				r.tm = TIME_W'((longint'(t) <<< 8) + frac);
				r.found = 1'b1;
				break;
			end
		end
		r.amp = AMP_W'(pk_amp);
		r.idx = IDX_W'(pk_idx);
		return r;
	endfunction

	// advance predictor by one sample; returns 1 if a pulse result is due
	function automatic bit peak_track(input int raw, input bit last, output pulse_res_t r);
		int v, idx;
		bit got;
		got = 0;
		r = '0;
		idx = wr_ptr;
		v = -raw;
		if (v > clamp_q) v = 0;
		wave_mem[idx] = v;
		if (v > thr_q) begin
			if (!pulse_on) begin
				pulse_on = 1;
				pk_amp = 0;
				pk_idx = idx;
			end
			if (v > pk_amp) begin
				pk_amp = v;
				pk_idx = idx;
			end
			if (last) begin
				r = cfd_search();
				got = 1;
				pulse_on = 0;
			end
		end else if (pulse_on) begin
			r = cfd_search();
			got = 1;
			pulse_on = 0;
		end
		if (last) begin
			wr_ptr = 0;
			pulse_on = 0;
		end else
			wr_ptr = (idx + 1) % NREC;
		return got;
	endfunction

	// returns right after the accepting edge
	task automatic send_sample(input int raw, input bit last, input bit typed,
			input pulse_res_t tres);
		pulse_res_t r;
		int rs;
		rs = int'($signed(16'(raw)));
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.raw_sample = 16'(rs);
		in_ch.last_in_record = last;
		do @(posedge clk); while (!in_ch.ready);
		if (peak_track(rs, last, r))
			pulse_q.push_back(typed ? tres : r);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pulse_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data = CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_THRESHOLD:   thr_q = val & 16'h7FFF;
			REG_CF_FRACTION: cf_q = val & 8'hFF;
			REG_CLAMP_LIMIT: clamp_q = val & 16'h7FFF;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic set_regs(input int thr, input int cf, input int clamp);
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_CF_FRACTION, cf);
		write_reg(REG_CLAMP_LIMIT, clamp);
	endtask

	function automatic int rand_sample(input int pos, input int plen, input int ppk);
		int v, k;
		k = $urandom_range(99);
		if (k < 8)
			return int'($signed(16'($urandom)));
		if (plen > 0) begin
			v = ppk * (plen - ((2 * pos + 1 - plen) < 0 ? plen - 2 * pos - 1
				: 2 * pos + 1 - plen)) / plen;
			v = v + $urandom_range(20) - 10;
			if (k < 14) v = clamp_q + $urandom_range(50);
			return -v;
		end
		if (k < 20) return $urandom_range(32767);
		return -$urandom_range(thr_q);
	endfunction

	// random records of noise and pulses
	task automatic run_records(input int n_items, input int max_len);
		int sent, len, i, plen, pos, ppk;
		pulse_res_t none;
		none = '0;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(max_len, 1)
				: $urandom_range(40, 1);
			plen = 0;
			pos = 0;
			ppk = 0;
			for (i = 0; i < len; i++) begin
				if (plen == 0 && $urandom_range(99) < 20) begin
					plen = $urandom_range(14, 1);
					pos = 0;
					ppk = thr_q + 1 + $urandom_range(clamp_q > thr_q ? clamp_q - thr_q : 1);
				end
				send_sample(rand_sample(pos, plen, ppk), i == len - 1, 1'b0, none);
				if (plen > 0 && ++pos >= plen) plen = 0;
				sent++;
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		pulse_res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pulse_q.size() == 0) begin
				$display("%0t: unexpected result amp=%0d idx=%0d time=%0d found=%0d",
					$time, out_ch.peak_amplitude, out_ch.peak_index, out_ch.cf_time,
					out_ch.cf_found);
				errors++;
			end else begin
				e = pulse_q.pop_front();
				if (out_ch.peak_amplitude !== e.amp) begin
					$display("%0t: peak_amplitude exp %0d got %0d", $time, e.amp,
						out_ch.peak_amplitude);
					errors++;
				end
				if (out_ch.peak_index !== e.idx) begin
					$display("%0t: peak_index exp %0d got %0d", $time, e.idx,
						out_ch.peak_index);
					errors++;
				end
				if (out_ch.cf_time !== e.tm) begin
					$display("%0t: cf_time exp %0d got %0d", $time, e.tm, out_ch.cf_time);
					errors++;
				end
				if (out_ch.cf_found !== e.found) begin
					$display("%0t: cf_found exp %0d got %0d", $time, e.found,
						out_ch.cf_found);
					errors++;
				end
			end
		end
	end

	// receiver ready, with optional long hold-off
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready = 1'b0;
			end else
				out_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		stim_row_t dir_tab[$];
		pulse_res_t none;
		int i;
		none = '0;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		thr_q = THRESHOLD_RST;
		cf_q = CF_RST;
		clamp_q = CLAMP_RST;
		wr_ptr = 0;
		pulse_on = 0;
		pk_amp = 0;
		pk_idx = 0;
		foreach (wave_mem[k]) wave_mem[k] = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.raw_sample = '0;
		in_ch.last_in_record = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_THRESHOLD;
		cfg.data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset registers: thr 100, cf 128, clamp 9000
		dir_tab = '{
			'{0,      0, 0, none},
			'{-1000,  0, 0, none},
			'{-2000,  0, 0, none},
			'{-2000,  0, 0, none},
			'{0,      0, 1, '{15'd2000, 12'd2, 20'd0, 1'b0}},  // level met exactly, never below it: no crossing
			'{-50,    0, 0, none},
			'{-400,   0, 0, none},
			'{-800,   0, 0, none},
			'{-32768, 0, 1, '{15'd800, 12'd7, 20'd1535, 1'b1}}, // clamped, frac saturates
			'{32767,  0, 0, none},
			'{-9000,  0, 0, none},
			'{-9001,  1, 0, none},                              // run ends with record
			'{-500,   1, 1, '{15'd500, 12'd0, 20'd0, 1'b0}},    // peak at index zero
			'{-300,   0, 0, none},
			'{-600,   1, 1, '{15'd600, 12'd1, 20'd0, 1'b0}},
			'{-101,   0, 0, none},
			'{-100,   0, 0, none},
			'{-32767, 1, 0, none}
		};
		for (i = 0; i < dir_tab.size(); i++)
			send_sample(dir_tab[i].raw, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);
		drain();

		// no idling
		set_regs(0, 255, 32767);
		run_records(400, 200);
		drain();
		// sender idles
		idle_pct = 68;
		set_regs($urandom_range(400), $urandom_range(255, 1), $urandom_range(32767));
		run_records(300, 200);
		drain();
		// receiver stalls
		idle_pct = 0;
		stall_pct = 68;
		set_regs(32767, 1, 0);
		run_records(60, 40);
		drain();
		set_regs($urandom_range(2000), $urandom_range(255, 1), $urandom_range(32767));
		run_records(300, 200);
		drain();
		// both
		idle_pct = 14;
		stall_pct = 14;
		set_regs(100, 128, 9000);
		run_records(300, 200);
		drain();
		// long receiver hold-off while samples keep coming
		idle_pct = 0;
		stall_pct = 0;
		set_regs(50, 200, 20000);
		hold_cycles = 600;
		run_records(150, 40);
		drain();
		set_regs($urandom_range(32767), $urandom_range(255, 1), $urandom_range(32767));
		idle_pct = 30;
		stall_pct = 30;
		run_records(400, 100);
		drain();

		if (errors == 0 && pulse_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
